>>> rtl/core/irti_pkg.sv
package irti_pkg;

  // Table shape
  localparam int TABLE_POINTS = 14;
  localparam int LAST_SEG     = TABLE_POINTS - 2;
  localparam int SEG_W        = 4;

  // Field widths
  localparam int SAMPLE_W  = 12;
  localparam int CM_W      = 7;
  localparam int DIST_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int STEP_CM   = 5;

  // Datapath widths
  localparam int DEN_W     = SAMPLE_W + 1;
  localparam int NUM_W     = 21;
  localparam int MAG_W     = NUM_W - 1;
  localparam int DVD_W     = MAG_W + FRAC_BITS + 2;
  localparam int REM_W     = SAMPLE_W + 2;
  localparam int DIV_STEPS = DVD_W / 2;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int DIST_MAX  = 2 ** (DIST_W - 1) - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SEG_W-1:0]    seg;
  } irti_item_t;

  // Breakpoint sample values, falling
  function automatic logic [SAMPLE_W-1:0] bp_at(input logic [SEG_W-1:0] idx);
    logic [SAMPLE_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd2570;
      4'd1:    v = 12'd1400;
      4'd2:    v = 12'd1000;
      4'd3:    v = 12'd750;
      4'd4:    v = 12'd600;
      4'd5:    v = 12'd503;
      4'd6:    v = 12'd370;
      4'd7:    v = 12'd270;
      4'd8:    v = 12'd190;
      4'd9:    v = 12'd120;
      4'd10:   v = 12'd80;
      4'd11:   v = 12'd60;
      4'd12:   v = 12'd40;
      4'd13:   v = 12'd38;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Distance at each breakpoint, cm
  function automatic logic [CM_W-1:0] cm_at(input logic [SEG_W-1:0] idx);
    logic [CM_W-1:0] v;
    if (idx < SEG_W'(TABLE_POINTS)) begin
      v = CM_W'((32'(idx) + 32'd1) * STEP_CM);
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

>>> rtl/core/irti_front.sv
module irti_front
  import irti_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                busy,
  output logic                push,
  output irti_item_t          item,
  input  logic                full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PUSH
  } state_t;

  state_t              state_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [SEG_W-1:0]    idx_r;
  logic [SEG_W-1:0]    seg_r;

  logic [SAMPLE_W-1:0] bp_cur;
  logic [SAMPLE_W-1:0] bp_nx;
  logic                hit;

  assign bp_cur = bp_at(idx_r);
  assign bp_nx  = bp_at(idx_r + SEG_W'(1));

  // exact hit on a breakpoint, or strictly inside any segment but the last
  assign hit = (sample_r == bp_cur) ||
               ((idx_r != SEG_W'(LAST_SEG)) && (sample_r < bp_cur) && (sample_r > bp_nx));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      seg_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            sample_r <= sample;
            idx_r    <= '0;
            state_r  <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            seg_r   <= idx_r;
            state_r <= ST_PUSH;
          end else if (idx_r == SEG_W'(LAST_SEG)) begin
            seg_r   <= '0;  // no match: extrapolate on the first segment
            state_r <= ST_PUSH;
          end else begin
            idx_r <= idx_r + SEG_W'(1);
          end
        end
        ST_PUSH: begin
          if (!full) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign push        = (state_r == ST_PUSH) && !full;
  assign item.sample = sample_r;
  assign item.seg    = seg_r;

  a_push_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (item.seg <= SEG_W'(LAST_SEG)))
    else $error("front pushed an out-of-range segment");

  a_search_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (idx_r <= SEG_W'(LAST_SEG)))
    else $error("search index ran past the last segment");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("front did not go busy after taking an item");

endmodule

>>> rtl/core/irti_fifo.sv
module irti_fifo
  import irti_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  irti_item_t wr_item,
  output logic       full,
  input  logic       pop,
  output irti_item_t rd_item,
  output logic       empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  irti_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_item = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

>>> rtl/core/irti_back.sv
module irti_back
  import irti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     empty,
  input  irti_item_t               item,
  output logic                     pop,
  output logic                     out_valid,
  output logic signed [DIST_W-1:0] out_distance_q8,
  output logic [SEG_W-1:0]         out_segment
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                    state_r;
  irti_item_t                item_r;
  logic signed [DEN_W-1:0]   den_r;
  logic signed [NUM_W-1:0]   num_r;
  logic                      flat_r;
  logic                      neg_r;
  logic [DVD_W-1:0]          dvd_r;   // dividend in, quotient shifts in from the bottom
  logic [REM_W-1:0]          rem_r;
  logic [DEN_W-1:0]          d2_r;
  logic [DCNT_W-1:0]         cnt_r;
  logic                      out_valid_r;
  logic signed [DIST_W-1:0]  dist_r;
  logic [SEG_W-1:0]          seg_out_r;

  // operand set-up
  logic [SAMPLE_W-1:0]       bp_cur;
  logic [SAMPLE_W-1:0]       bp_nx;
  logic signed [DEN_W-1:0]   den_c;
  logic signed [DEN_W-1:0]   diff_c;
  logic signed [NUM_W-1:0]   cm_x;
  logic signed [NUM_W-1:0]   den_x;
  logic signed [NUM_W-1:0]   diff_x;
  logic signed [NUM_W-1:0]   num_c;
  logic [MAG_W-1:0]          mag_c;

  // two restoring steps per cycle
  logic [REM_W-1:0]          d2_x;
  logic [REM_W-1:0]          sh1;
  logic [REM_W-1:0]          r1;
  logic [REM_W-1:0]          sh2;
  logic [REM_W-1:0]          r2;
  logic                      ge1;
  logic                      ge2;

  logic signed [DIST_W-1:0]  res_c;

  assign bp_cur = bp_at(item_r.seg);
  assign bp_nx  = bp_at(item_r.seg + SEG_W'(1));
  assign den_c  = $signed({1'b0, bp_cur}) - $signed({1'b0, bp_nx});
  assign diff_c = $signed({1'b0, bp_cur}) - $signed({1'b0, item_r.sample});
  assign cm_x   = NUM_W'($signed({1'b0, cm_at(item_r.seg)}));
  assign den_x  = NUM_W'(den_c);
  assign diff_x = NUM_W'(diff_c);
  assign num_c  = cm_x * den_x + (diff_x <<< 2) + diff_x;

  assign mag_c  = num_r[NUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);

  assign d2_x = REM_W'(d2_r);
  assign sh1  = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign ge1  = (sh1 >= d2_x);
  assign r1   = ge1 ? (sh1 - d2_x) : sh1;
  assign sh2  = {r1[REM_W-2:0], dvd_r[DVD_W-2]};
  assign ge2  = (sh2 >= d2_x);
  assign r2   = ge2 ? (sh2 - d2_x) : sh2;

  always_comb begin
    if (flat_r) begin
      res_c = DIST_W'($signed({1'b0, cm_at(item_r.seg), {FRAC_BITS{1'b0}}}));
    end else if (neg_r) begin
      if (dvd_r > DVD_W'(DIST_MAX + 1)) begin
        res_c = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
        res_c = -$signed(dvd_r[DIST_W-1:0]);
      end
    end else begin
      if (dvd_r > DVD_W'(DIST_MAX)) begin
        res_c = DIST_W'(DIST_MAX);
      end else begin
        res_c = $signed(dvd_r[DIST_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (!empty) begin
            item_r  <= item;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          den_r   <= den_c;
          num_r   <= num_c;
          flat_r  <= (den_c <= 0);
          state_r <= ST_PREP;
        end
        ST_PREP: begin
          // round half away from zero: (2|n|*256 + d) / 2d
          neg_r   <= num_r[NUM_W-1];
          dvd_r   <= {1'b0, mag_c, {FRAC_BITS{1'b0}}, 1'b0} + DVD_W'(den_r[DEN_W-2:0]);
          d2_r    <= {den_r[DEN_W-2:0], 1'b0};
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= flat_r ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          rem_r <= r2;
          dvd_r <= {dvd_r[DVD_W-3:0], ge1, ge2};
          cnt_r <= cnt_r + DCNT_W'(1);
          if (cnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_r <= 1'b1;
          dist_r      <= res_c;
          seg_out_r   <= item_r.seg;
          state_r     <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign pop             = (state_r == ST_IDLE) && !empty;
  assign out_valid       = out_valid_r;
  assign out_distance_q8 = dist_r;
  assign out_segment     = seg_out_r;

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_out_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (seg_out_r <= SEG_W'(LAST_SEG)))
    else $error("result segment out of range");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (d2_r != '0))
    else $error("divider running with a zero divisor");

endmodule

>>> rtl/core/ir_sensor_table_interpolator.sv
// Converts a 12-bit infrared distance sensor reading to centimetres by linear interpolation
// in a fixed 14-point table (2570..38 counts mapping to 5..70 cm). The result is signed Q8,
// rounded to nearest, with the table segment used. Samples outside the table, the last
// breakpoint itself and the count just above it extrapolate on the first segment. Drive
// start with the sample while busy is low; the item is taken on that edge. Each result
// appears for exactly one cycle with out_valid high and must be captured then, as the block
// cannot be held off. The front end finds the segment one breakpoint a cycle, then hands
// the item to a two-entry queue; it takes no new item until that hand-over is done. The back
// end takes one item at a time from the queue: load, multiply, set-up, a two-bit-per-cycle
// restoring divider, and output. The divider sets the sustained rate. busy is high while the
// front end is searching or handing the item over, which stretches while the queue is full.
module ir_sensor_table_interpolator
  import irti_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [SAMPLE_W-1:0]      in_adc_sample,
  output logic                     out_valid,
  output logic signed [DIST_W-1:0] out_distance_q8,
  output logic [SEG_W-1:0]         out_segment
);

  // front end to queue
  logic       fe_push;
  irti_item_t fe_item;
  logic       q_full;

  // queue to back end
  logic       be_pop;
  irti_item_t q_item;
  logic       q_empty;

  // segment search, one breakpoint per cycle
  irti_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sample (in_adc_sample),
    .busy   (busy),
    .push   (fe_push),
    .item   (fe_item),
    .full   (q_full)
  );

  // decouples search from arithmetic
  irti_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fe_push),
    .wr_item (fe_item),
    .full    (q_full),
    .pop     (be_pop),
    .rd_item (q_item),
    .empty   (q_empty)
  );

  // multiply, divide with rounding, saturate
  irti_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty           (q_empty),
    .item            (q_item),
    .pop             (be_pop),
    .out_valid       (out_valid),
    .out_distance_q8 (out_distance_q8),
    .out_segment     (out_segment)
  );

endmodule

>>> tb/tb_ir_sensor_table_interpolator.sv
module tb_ir_sensor_table_interpolator;
  import irti_pkg::*;

  // Run limit: several times the slowest legal run
  // (every item behind a long gap, full search and divide).
  localparam int CLK_HALF     = 10;
  localparam int RUN_LIMIT    = 20_000_000;
  localparam int RANDOM_ITEMS = 1950;
  // Drain longer than the longest single-item latency.
  localparam int DRAIN_CYCLES = 50;
  localparam int MAX_PRINTS   = 40;

  // One result as the block should produce it; the sample travels along
  // so that mismatch lines can name the item that caused them.
  typedef struct {
    logic [SAMPLE_W-1:0]      sample;
    logic signed [DIST_W-1:0] distance;
    logic [SEG_W-1:0]         seg;
  } reading_t;

  // Directed row: 'known' marks rows whose result is typed in by hand.
  typedef struct {
    logic [SAMPLE_W-1:0]      sample;
    bit                       known;
    logic signed [DIST_W-1:0] distance;
    logic [SEG_W-1:0]         seg;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [SAMPLE_W-1:0]      in_adc_sample;
  logic                     out_valid;
  logic signed [DIST_W-1:0] out_distance_q8;
  logic [SEG_W-1:0]         out_segment;

  reading_t  expected_readings[$];
  stim_row_t directed_rows[$];

  int n_sent      = 0;
  int n_directed  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  bit burst_mode  = 1'b0;

  ir_sensor_table_interpolator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_distance_q8 (out_distance_q8),
    .out_segment     (out_segment)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Breakpoint sample values, falling from 2570 to 38.
  function automatic int breakpoint(input int idx);
    int v;
    case (idx)
      0:       v = 2570;
      1:       v = 1400;
      2:       v = 1000;
      3:       v = 750;
      4:       v = 600;
      5:       v = 503;
      6:       v = 370;
      7:       v = 270;
      8:       v = 190;
      9:       v = 120;
      10:      v = 80;
      11:      v = 60;
      12:      v = 40;
      13:      v = 38;
      default: v = 0;
    endcase
    return v;
  endfunction

  // First match wins: exact hit on a breakpoint, or strictly inside a
  // segment (never the last one). Anything else falls back to segment 0,
  // which then extrapolates - above 2570, at or below 38, and 39.
  function automatic int find_segment(input int s);
    int i;
    for (i = 0; i <= TABLE_POINTS - 2; i++) begin
      if (s == breakpoint(i)) return i;
      if (i < TABLE_POINTS - 2 && s < breakpoint(i) && s > breakpoint(i + 1)) return i;
    end
    return 0;
  endfunction

  // dist[i] + 5*(bp[i]-s)/(bp[i]-bp[i+1]) in Q8, rounded half away from
  // zero, saturated to 16 bits signed.
  function automatic reading_t interpolate(input logic [SAMPLE_W-1:0] sample);
    int       s;
    int       seg;
    longint   den;
    longint   num;
    longint   q;
    reading_t r;
    s   = int'(sample);
    seg = find_segment(s);
    den = longint'(breakpoint(seg)) - longint'(breakpoint(seg + 1));
    if (den > 0) begin
      num = longint'((seg + 1) * STEP_CM) * den
          + longint'(STEP_CM) * (longint'(breakpoint(seg)) - longint'(s));
      num = num * (longint'(1) << FRAC_BITS);
      if (num >= 0) q = (2 * num + den) / (2 * den);
      else          q = -((-2 * num + den) / (2 * den));
    end else begin
      // zero-width segment: flat at the left-hand distance
      q = longint'((seg + 1) * STEP_CM) * (longint'(1) << FRAC_BITS);
    end
    if (q > DIST_MAX)        q = DIST_MAX;
    if (q < -DIST_MAX - 1)   q = -DIST_MAX - 1;
    r.sample   = sample;
    r.distance = q[DIST_W-1:0];
    r.seg      = seg[SEG_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_row(input int sample, input bit known, input int distance, input int seg);
    stim_row_t row;
    row.sample   = sample[SAMPLE_W-1:0];
    row.known    = known;
    row.distance = distance[DIST_W-1:0];
    row.seg      = seg[SEG_W-1:0];
    directed_rows.push_back(row);
  endtask

  // Mostly back-to-back, some short gaps, a few long ones; burst mode
  // gives stretches with no idling at all.
  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 79) == 0) burst_mode = ~burst_mode;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Random sample: full range, segment interiors, breakpoint edges and the
  // dense low end where the short segments and fallback cases live.
  function automatic logic [SAMPLE_W-1:0] random_sample();
    int sel;
    int k;
    int v;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      v = $urandom_range(0, (1 << SAMPLE_W) - 1);
    end else if (sel < 6) begin
      k = $urandom_range(0, TABLE_POINTS - 3);
      v = $urandom_range(breakpoint(k + 1), breakpoint(k));
    end else if (sel < 8) begin
      k = $urandom_range(0, TABLE_POINTS - 1);
      v = breakpoint(k) + $urandom_range(0, 6) - 3;
    end else begin
      v = $urandom_range(0, 130);
    end
    if (v < 0) v = 0;
    if (v > (1 << SAMPLE_W) - 1) v = (1 << SAMPLE_W) - 1;
    return v[SAMPLE_W-1:0];
  endfunction

  // Present one item, hold it until taken (start high, busy low at an
  // edge) and queue what should come back. start stays high on exit so
  // that a following item can go straight out.
  task automatic offer_sample(input stim_row_t row);
    int       gap;
    reading_t want;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_adc_sample <= row.sample;
    do @(posedge clk); while (busy);
    if (row.known) begin
      want.sample   = row.sample;
      want.distance = row.distance;
      want.seg      = row.seg;
    end else begin
      want = interpolate(row.sample);
    end
    expected_readings.push_back(want);
    n_sent++;
  endtask

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: results cannot be held off, so every strobe is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("result with nothing awaited: dist=%0d seg=%0d",
                                out_distance_q8, out_segment));
      end else begin
        want = expected_readings.pop_front();
        n_checked++;
        if (out_distance_q8 !== want.distance)
          flag_mismatch($sformatf("sample %0d: distance %0d, want %0d",
                                  want.sample, out_distance_q8, want.distance));
        if (out_segment !== want.seg)
          flag_mismatch($sformatf("sample %0d: segment %0d, want %0d",
                                  want.sample, out_segment, want.seg));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    start         <= 1'b0;
    in_adc_sample <= '0;
    rst_n         <= 1'b0;

    // Exact breakpoints: result is the table distance in Q8.
    add_row(2570, 1, 1280,  0);
    add_row(1400, 1, 2560,  1);
    add_row(1000, 1, 3840,  2);
    add_row(750,  1, 5120,  3);
    add_row(503,  1, 7680,  5);
    add_row(120,  1, 12800, 9);
    add_row(60,   1, 15360, 11);
    add_row(40,   1, 16640, 12);
    // Field extremes and single-bit patterns
    add_row(0,    0, 0, 0);
    add_row(4095, 0, 0, 0);
    add_row(1,    0, 0, 0);
    add_row(2048, 0, 0, 0);
    add_row(2047, 0, 0, 0);
    add_row(4094, 0, 0, 0);
    // Either side of the first two breakpoints; 2571 extrapolates upwards
    add_row(2571, 0, 0, 0);
    add_row(2569, 0, 0, 0);
    add_row(1401, 0, 0, 0);
    add_row(1399, 0, 0, 0);
    // Low end: 37, the last breakpoint and 39 fall back to segment 0
    add_row(38,   0, 0, 0);
    add_row(39,   0, 0, 0);
    add_row(37,   0, 0, 0);
    add_row(41,   0, 0, 0);
    add_row(59,   0, 0, 0);
    add_row(61,   0, 0, 0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) offer_sample(directed_rows[i]);
    n_directed = n_sent;

    row.known    = 1'b0;
    row.distance = '0;
    row.seg      = '0;
    repeat (RANDOM_ITEMS) begin
      row.sample = random_sample();
      offer_sample(row);
    end
    start <= 1'b0;

    while (expected_readings.size() != 0) @(posedge clk);
    // catch anything stray after the last result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d items sent (%0d directed, %0d random), %0d results checked",
             n_sent, n_directed, n_sent - n_directed, n_checked);
    $display("Summary: %0d mismatches", n_errors);
    if (n_errors == 0 && expected_readings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT);
    $display("Timeout with %0d results outstanding", expected_readings.size());
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/irti_pkg.sv
rtl/core/irti_front.sv
rtl/core/irti_fifo.sv
rtl/core/irti_back.sv
rtl/core/ir_sensor_table_interpolator.sv
tb/tb_ir_sensor_table_interpolator.sv
